### hdl/lgti_pkg.sv
// ----------------------------------------------------------------------------
// lgti_pkg
// Shared types and constants for the log-grid trilinear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package lgti_pkg;

  // Default grid sizes
  localparam int NTEMP_DEF = 16;
  localparam int NIN_DEF   = 32;
  localparam int NOUT_DEF  = 32;

  // Field widths
  localparam int VAL_W  = 32;
  localparam int STEP_W = 31;
  localparam int TADDR_W = 15;
  localparam int IN_DATA_W = 144;

  // Reset value of the step registers (1.0 in Q8.24)
  localparam logic [STEP_W-1:0] STEP_RST = 31'd16777216;

  // Command codes carried in in_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_TEMP_MIN  = 3'd0;
  localparam logic [2:0] CFG_TEMP_STEP = 3'd1;
  localparam logic [2:0] CFG_IN_MIN    = 3'd2;
  localparam logic [2:0] CFG_IN_STEP   = 3'd3;
  localparam logic [2:0] CFG_OUT_MIN   = 3'd4;
  localparam logic [2:0] CFG_OUT_STEP  = 3'd5;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOC,
    ST_LWAIT,
    ST_ADDR,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_DIFF,
    ST_MUL,
    ST_DGO,
    ST_DWAIT,
    ST_OUT
  } state_t;

  // Axis being located
  typedef enum logic [1:0] {
    AX_T,
    AX_I,
    AX_O
  } axis_t;

  // Linear steps of one query, in order
  typedef enum logic [2:0] {
    LP_O00,
    LP_O01,
    LP_I0,
    LP_O10,
    LP_O11,
    LP_I1,
    LP_T
  } lerp_t;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [31:0]       hi;
    logic [31:0]       lo;
    logic [STEP_W-1:0] divisor;
    logic [5:0]        iters;
  } div_req_t;

  // Status from the shared divider
  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### hdl/lgti_ram.sv
// ----------------------------------------------------------------------------
// lgti_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lgti_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/lgti_div.sv
// ----------------------------------------------------------------------------
// lgti_div
// Shared restoring divider, one quotient bit per cycle. The remainder starts
// at the high word (below the divisor) and the low word is shifted in.
// ----------------------------------------------------------------------------
`default_nettype none

module lgti_div
  import lgti_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic [31:0]       rem_r;
  logic [31:0]       sh_r;
  logic [31:0]       quo_r;
  logic [STEP_W-1:0] dvs_r;

  logic [31:0] trial;
  logic [32:0] sub;

  // Trial subtract of one step
  assign trial = {rem_r[30:0], sh_r[31]};
  assign sub   = {1'b0, trial} - {2'b00, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.hi;
      sh_r  <= req.lo;
      quo_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      sh_r <= {sh_r[30:0], 1'b0};
      if (!sub[32]) begin
        rem_r <= sub[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

### hdl/log_grid_trilinear_interpolator.sv
// ----------------------------------------------------------------------------
// log_grid_trilinear_interpolator
// Trilinear interpolation over a table on grids uniform in natural log, with
// a range check on every axis. One divider and one multiplier are shared.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// in_       in   tuser: command; tdata: table_address, table_value,
//                log_temp, log_inprime, log_out
// out_      out  tuser: out_of_range; tdata: interp_value
// cfg_      in   cfg_index selects register, cfg_wr_data carries value
//
// A table write is stored directly from idle. A query runs three locates
// (8-bit divide each), then seven linear steps with a 32-bit divide each,
// plus the four corner-pair reads.
// in_tready is high only while the sequencer is idle; a finished result
// waits in the output register while the next item is taken.
// Reset is synchronous, active low; the table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module log_grid_trilinear_interpolator
  import lgti_pkg::*;
#(
  parameter int NTEMP = NTEMP_DEF,
  parameter int NIN   = NIN_DEF,
  parameter int NOUT  = NOUT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,  // table_address, table_value,
                                               // log_temp, log_inprime, log_out
  input  wire logic                 in_tuser,  // command
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [VAL_W-1:0]     out_tdata, // interp_value
  output logic                      out_tuser, // out_of_range
  input  wire logic                 cfg_wr_en,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [31:0]          cfg_wr_data
);

  localparam int DEPTH = NTEMP * NIN * NOUT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0] NM2_T = 9'(NTEMP - 2);
  localparam logic [8:0] NM2_I = 9'(NIN - 2);
  localparam logic [8:0] NM2_O = 9'(NOUT - 2);

  // Configuration registers
  logic [31:0]       tmin_r, imin_r, omin_r;
  logic [STEP_W-1:0] tstep_r, istep_r, ostep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmin_r  <= '0;
      imin_r  <= '0;
      omin_r  <= '0;
      tstep_r <= STEP_RST;
      istep_r <= STEP_RST;
      ostep_r <= STEP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEMP_MIN:  tmin_r  <= cfg_wr_data;
        CFG_TEMP_STEP: tstep_r <= cfg_wr_data[STEP_W-1:0];
        CFG_IN_MIN:    imin_r  <= cfg_wr_data;
        CFG_IN_STEP:   istep_r <= cfg_wr_data[STEP_W-1:0];
        CFG_OUT_MIN:   omin_r  <= cfg_wr_data;
        CFG_OUT_STEP:  ostep_r <= cfg_wr_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input field split
  logic [TADDR_W-1:0] f_addr;
  logic [31:0]        f_value, f_ltemp, f_lin, f_lout;
  assign f_addr  = in_tdata[14:0];
  assign f_value = in_tdata[46:15];
  assign f_ltemp = in_tdata[78:47];
  assign f_lin   = in_tdata[110:79];
  assign f_lout  = in_tdata[142:111];

  state_t state_r, state_nxt;
  axis_t  ax_r;
  lerp_t  lj_r;
  logic   in_acc;

  logic [31:0]       ct_r, ci_r, co_r;
  logic [7:0]        kt_r, ki_r, ko_r;
  logic [STEP_W-1:0] ft_r, fi_r, fo_r;
  logic [AW-1:0]     base_r;
  logic [31:0]       a_r, b_r, h0_r, h1_r, mag_r, res_r;
  logic              neg_r, oor_r;
  logic [62:0]       prod_r;
  logic              out_valid_r, out_oor_r;
  logic [31:0]       out_data_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // Table store
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata, waddr32;

  assign waddr32   = 32'(f_addr);
  assign ram_we    = in_acc & (in_tuser == CMD_WRITE) & (waddr32 < 32'(DEPTH));
  assign ram_waddr = AW'(waddr32);

  lgti_ram #(.W(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (f_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  lgti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Locate operands of the current axis
  logic [31:0]       loc_c, loc_m;
  logic [STEP_W-1:0] loc_s;
  logic [8:0]        loc_nm2;
  logic [32:0]       loc_d;
  logic [31:0]       loc_dm1;
  logic              loc_bad;

  always_comb begin
    unique case (ax_r)
      AX_T:    begin loc_c = ct_r; loc_m = tmin_r; loc_s = tstep_r; loc_nm2 = NM2_T; end
      AX_I:    begin loc_c = ci_r; loc_m = imin_r; loc_s = istep_r; loc_nm2 = NM2_I; end
      AX_O:    begin loc_c = co_r; loc_m = omin_r; loc_s = ostep_r; loc_nm2 = NM2_O; end
      default: begin loc_c = co_r; loc_m = omin_r; loc_s = ostep_r; loc_nm2 = NM2_O; end
    endcase
    loc_d   = {loc_c[31], loc_c} - {loc_m[31], loc_m};
    loc_dm1 = loc_d[31:0] - 32'd1;
    // Zero step, d <= 0, or quotient of 256 or more
    loc_bad = (loc_s == '0) || loc_d[32] || (loc_d == '0) ||
              ({7'd0, loc_dm1} >= {loc_s, 8'd0});
  end

  // Fraction and step of the current linear step
  logic [STEP_W-1:0] lp_f, lp_s;
  logic              rd_t, rd_i;

  always_comb begin
    unique case (lj_r)
      LP_O00, LP_O01, LP_O10, LP_O11: begin lp_f = fo_r; lp_s = ostep_r; end
      LP_I0, LP_I1:                   begin lp_f = fi_r; lp_s = istep_r; end
      LP_T:                           begin lp_f = ft_r; lp_s = tstep_r; end
      default:                        begin lp_f = ft_r; lp_s = tstep_r; end
    endcase
    rd_t = (lj_r == LP_O10) || (lj_r == LP_O11);
    rd_i = (lj_r == LP_O01) || (lj_r == LP_O11);
  end

  // Corner read address
  logic [31:0] rd_off;
  assign rd_off = (rd_t ? 32'(NIN * NOUT) : 32'd0) + (rd_i ? 32'(NOUT) : 32'd0) +
                  ((state_r == ST_RDB) ? 32'd1 : 32'd0);
  assign ram_raddr = AW'(32'(base_r) + rd_off);

  // Lerp result: a + floor(signed product / step)
  logic [33:0] lp_res;
  logic        rem_nz;
  assign rem_nz = (div_rsp.rem != '0);
  assign lp_res = neg_r ?
    ({{2{a_r[31]}}, a_r} - {2'b00, div_rsp.quo} - {33'd0, rem_nz}) :
    ({{2{a_r[31]}}, a_r} + {2'b00, div_rsp.quo});

  // Next state and divider requests
  always_comb begin
    state_nxt       = state_r;
    div_req.start   = 1'b0;
    div_req.hi      = {8'd0, loc_dm1[31:8]};
    div_req.lo      = {loc_dm1[7:0], 24'd0};
    div_req.divisor = loc_s;
    div_req.iters   = 6'd8;
    unique case (state_r)
      ST_IDLE:  if (in_acc && (in_tuser == CMD_QUERY)) state_nxt = ST_LOC;
      ST_LOC: begin
        if (loc_bad) begin
          state_nxt = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        if (div_rsp.done) begin
          if ({1'b0, div_rsp.quo[7:0]} > loc_nm2) state_nxt = ST_OUT;
          else if (ax_r == AX_O)                  state_nxt = ST_ADDR;
          else                                    state_nxt = ST_LOC;
        end
      end
      ST_ADDR:  state_nxt = ST_RDA;
      ST_RDA:   state_nxt = ST_RDB;
      ST_RDB:   state_nxt = ST_RDC;
      ST_RDC:   state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DGO;
      ST_DGO: begin
        div_req.start   = 1'b1;
        div_req.hi      = {1'b0, prod_r[62:32]};
        div_req.lo      = prod_r[31:0];
        div_req.divisor = lp_s;
        div_req.iters   = 6'd32;
        state_nxt       = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          unique case (lj_r)
            LP_O00, LP_I0, LP_O10: state_nxt = ST_RDA;
            LP_T:                  state_nxt = ST_OUT;
            default:               state_nxt = ST_DIFF;
          endcase
        end
      end
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Query datapath
  logic [31:0] base32;
  assign base32 = (32'(kt_r) * 32'(NIN) + 32'(ki_r)) * 32'(NOUT) + 32'(ko_r);

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        ct_r  <= f_ltemp;
        ci_r  <= f_lin;
        co_r  <= f_lout;
        ax_r  <= AX_T;
        oor_r <= 1'b1;
      end
      ST_LWAIT: begin
        if (div_rsp.done) begin
          unique case (ax_r)
            AX_T:    begin kt_r <= div_rsp.quo[7:0]; ft_r <= div_rsp.rem[30:0] + 31'd1; end
            AX_I:    begin ki_r <= div_rsp.quo[7:0]; fi_r <= div_rsp.rem[30:0] + 31'd1; end
            default: begin ko_r <= div_rsp.quo[7:0]; fo_r <= div_rsp.rem[30:0] + 31'd1; end
          endcase
          if (ax_r == AX_T) ax_r <= AX_I;
          else              ax_r <= AX_O;
        end
      end
      ST_ADDR: begin
        base_r <= AW'(base32);
        lj_r   <= LP_O00;
      end
      ST_RDB: a_r <= ram_rdata;
      ST_RDC: b_r <= ram_rdata;
      ST_DIFF: begin
        neg_r <= ($signed(b_r) < $signed(a_r));
        mag_r <= ($signed(b_r) < $signed(a_r)) ? (a_r - b_r) : (b_r - a_r);
      end
      ST_MUL: prod_r <= 63'(mag_r) * 63'(lp_f);
      ST_DWAIT: begin
        if (div_rsp.done) begin
          res_r <= lp_res[31:0];
          unique case (lj_r)
            LP_O00: begin h0_r <= lp_res[31:0]; lj_r <= LP_O01; end
            LP_O01: begin a_r <= h0_r; b_r <= lp_res[31:0]; lj_r <= LP_I0; end
            LP_I0:  begin h1_r <= lp_res[31:0]; lj_r <= LP_O10; end
            LP_O10: begin h0_r <= lp_res[31:0]; lj_r <= LP_O11; end
            LP_O11: begin a_r <= h0_r; b_r <= lp_res[31:0]; lj_r <= LP_I1; end
            LP_I1:  begin a_r <= h1_r; b_r <= lp_res[31:0]; lj_r <= LP_T; end
            LP_T:   oor_r <= 1'b0;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
      out_oor_r  <= oor_r;
      out_data_r <= oor_r ? 32'd0 : res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

  // Checks
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_LWAIT) || (state_r == ST_DWAIT))
    else $error("divider result with no waiting state");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("out-of-range result carries a value");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> (state_r == ST_OUT) || (state_r == ST_IDLE))
    else $error("output state left for a busy state");

endmodule

`default_nettype wire

### bench/log_grid_trilinear_interpolator_tb.sv
// ----------------------------------------------------------------------------
// log_grid_trilinear_interpolator_tb
// Self-checking bench for the log-grid trilinear interpolator. Table writes
// and queries are streamed in with random gaps and result back-pressure; a
// scoreboard mirrors the table and grid registers and predicts every query.
// ----------------------------------------------------------------------------
`default_nettype none

module log_grid_trilinear_interpolator_tb;
  import lgti_pkg::*;

  localparam int NT = NTEMP_DEF;
  localparam int NI = NIN_DEF;
  localparam int NO = NOUT_DEF;
  localparam int DEPTH = NT * NI * NO;
  localparam int SETTLE = 400;

  typedef struct {
    logic [31:0] value;
    logic        oor;
  } interp_res_t;

  // Mirror of the block: table, grid registers and pending results
  class interp_scoreboard;
    logic [31:0] words [DEPTH];
    bit          written [DEPTH];
    longint      grid_min [3];
    longint      grid_step [3];
    interp_res_t pending_q [$];
    int          errors;

    function new();
      for (int a = 0; a < 3; a++) begin
        grid_min[a]  = 0;
        grid_step[a] = 64'd16777216;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CFG_TEMP_MIN:  grid_min[AX_T]  = longint'(signed'(v));
        CFG_TEMP_STEP: grid_step[AX_T] = longint'(v[30:0]);
        CFG_IN_MIN:    grid_min[AX_I]  = longint'(signed'(v));
        CFG_IN_STEP:   grid_step[AX_I] = longint'(v[30:0]);
        CFG_OUT_MIN:   grid_min[AX_O]  = longint'(signed'(v));
        CFG_OUT_STEP:  grid_step[AX_O] = longint'(v[30:0]);
        default: ;
      endcase
    endfunction

    function int axis_len(axis_t ax);
      return (ax == AX_T) ? NT : (ax == AX_I) ? NI : NO;
    endfunction

    // lower node k with node k < L <= node k+1; f in (0, step]
    function bit locate(axis_t ax, logic [31:0] c, output longint k, output longint f);
      longint d;
      d = longint'(signed'(c)) - grid_min[ax];
      k = 0;
      f = 0;
      if (grid_step[ax] <= 0 || d <= 0) return 0;
      k = (d - 1) / grid_step[ax];
      if (k > axis_len(ax) - 2) return 0;
      f = d - k * grid_step[ax];
      return 1;
    endfunction

    function int addr_of(longint t, longint i, longint o);
      return int'((t * NI + i) * NO + o);
    endfunction

    function longint word_at(longint t, longint i, longint o);
      return longint'(signed'(words[addr_of(t, i, o)]));
    endfunction

    function longint lerp(longint a, longint b, longint f, longint s);
      longint num, q;
      num = (b - a) * f;
      q = num / s;
      if ((num % s) != 0 && num < 0) q--;
      return a + q;
    endfunction

    function void note(bit cmd, logic [14:0] addr, logic [31:0] v,
                       logic [31:0] lt, logic [31:0] li, logic [31:0] lo);
      longint kt, ki, ko, ft, fi, fo, p1, p2, r;
      interp_res_t e;
      if (cmd == CMD_WRITE) begin
        if (addr < DEPTH) begin
          words[addr]   = v;
          written[addr] = 1;
        end
        return;
      end
      if (!locate(AX_T, lt, kt, ft) || !locate(AX_I, li, ki, fi) ||
          !locate(AX_O, lo, ko, fo)) begin
        e.value = '0;
        e.oor   = 1;
      end else begin
        p1 = lerp(lerp(word_at(kt, ki, ko), word_at(kt, ki, ko + 1), fo, grid_step[AX_O]),
                  lerp(word_at(kt, ki + 1, ko), word_at(kt, ki + 1, ko + 1), fo,
                       grid_step[AX_O]), fi, grid_step[AX_I]);
        p2 = lerp(lerp(word_at(kt + 1, ki, ko), word_at(kt + 1, ki, ko + 1), fo,
                       grid_step[AX_O]),
                  lerp(word_at(kt + 1, ki + 1, ko), word_at(kt + 1, ki + 1, ko + 1), fo,
                       grid_step[AX_O]), fi, grid_step[AX_I]);
        r = lerp(p1, p2, ft, grid_step[AX_T]);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        e.value = r[31:0];
        e.oor   = 0;
      end
      pending_q.push_back(e);
    endfunction

    function void check(logic [31:0] v, logic oor);
      interp_res_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value=%h oor=%b", $time, v, oor);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (v !== e.value) begin
        $display("%0t: interp_value mismatch expected=%h actual=%h", $time, e.value, v);
        errors++;
      end
      if (oor !== e.oor) begin
        $display("%0t: out_of_range mismatch expected=%b actual=%b", $time, e.oor, oor);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [VAL_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 cfg_wr_en;
  logic [2:0]           cfg_index;
  logic [31:0]          cfg_wr_data;

  interp_scoreboard sb;
  bit quiet;
  bit press_go;

  log_grid_trilinear_interpolator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Send one transfer, with an optional gap in front of it
  task send_item(bit cmd, logic [14:0] addr, logic [31:0] v,
                 logic [31:0] lt, logic [31:0] li, logic [31:0] lo);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, lo, li, lt, v, addr};
    do @(posedge clk); while (!in_tready);
    sb.note(cmd, addr, v, lt, li, lo);
  endtask

  task write_word(int addr, logic [31:0] v);
    send_item(CMD_WRITE, addr[14:0], v, $urandom, $urandom, $urandom);
  endtask

  function logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Query; every corner it will read is written first if still unknown
  task run_query(logic [31:0] lt, logic [31:0] li, logic [31:0] lo);
    longint kt, ki, ko, f;
    int a;
    if (sb.locate(AX_T, lt, kt, f) && sb.locate(AX_I, li, ki, f) &&
        sb.locate(AX_O, lo, ko, f)) begin
      for (int c = 0; c < 8; c++) begin
        a = sb.addr_of(kt + c[2], ki + c[1], ko + c[0]);
        if (!sb.written[a]) write_word(a, pick_word());
      end
    end
    send_item(CMD_QUERY, 15'($urandom), $urandom, lt, li, lo);
  endtask

  // Coordinate inside the grid of one axis, or a raw word if it won't fit;
  // the lower node stays near either end so the corner words get reused
  function logic [31:0] grid_coord(axis_t ax);
    longint s, k, f, c;
    s = sb.grid_step[ax];
    if (s <= 0) return $urandom;
    case ($urandom_range(0, 3))
      0: k = 0;
      1: k = sb.axis_len(ax) - 2;
      default: k = $urandom_range(0, 2);
    endcase
    case ($urandom_range(0, 3))
      0: f = 1;
      1: f = s;
      default: f = $urandom_range(1, s);
    endcase
    c = sb.grid_min[ax] + k * s + f;
    if (c > 64'sd2147483647 || c < -64'sd2147483648) return $urandom;
    return c[31:0];
  endfunction

  task set_regs(logic [31:0] v [6]);
    for (int r = 0; r < 6; r++) begin
      cfg_wr_en   <= 1;
      cfg_index   <= r[2:0];
      cfg_wr_data <= v[r];
      @(posedge clk);
      sb.set_reg(r[2:0], v[r]);
    end
    cfg_wr_en <= 0;
  endtask

  task apply_mode(int mode);
    logic [31:0] v [6];
    for (int a = 0; a < 3; a++) begin
      v[2*a]   = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
      v[2*a+1] = $urandom_range(1, 32'h0020_0000);
    end
    case (mode)
      0: v = '{32'h0, 32'h0100_0000, 32'h0, 32'h0100_0000, 32'h0, 32'h0100_0000};
      1: v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFE0, 32'h1,
               32'hC000_0000, 32'hFFFF_FFFF};
      3: v[2*$urandom_range(0, 2)+1] = 32'h8000_0000;  // step masks to zero
      default: ;
    endcase
    set_regs(v);
  endtask

  // Wait until every result is back and the block has gone quiet
  task drain();
    in_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Result side: checks and back-pressure
  initial begin
    int stall_left;
    int press_cnt;
    bit press_done;
    stall_left = 0;
    press_cnt  = 0;
    press_done = 0;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
      if (press_cnt > 0) begin
        press_cnt--;
        out_tready <= 0;
      end else if (press_go && !press_done) begin
        press_done = 1;
        press_cnt  = 2500;
        out_tready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  initial begin
    #(12 * 3_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int modes [10] = '{1, 2, 3, 2, 0, 2, 1, 2, 3, 2};
    sb = new();
    quiet       = 0;
    press_go    = 0;
    rst_n       = 0;
    in_tvalid   = 0;
    in_tuser    = 0;
    in_tdata    = '0;
    cfg_wr_en   = 0;
    cfg_index   = '0;
    cfg_wr_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: writes beyond the table, extreme words, grid edges
    write_word(DEPTH, 32'h1234_5678);
    write_word(32767, 32'hFFFF_FFFF);
    for (int c = 0; c < 8; c++)
      write_word(sb.addr_of(c[2], c[1], c[0]), c[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    run_query(32'h0080_0000, 32'h0080_0000, 32'h0080_0000);
    run_query(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
    run_query(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    run_query((NT - 1) << 24, (NI - 1) << 24, (NO - 1) << 24);
    run_query(32'h0, 32'h0080_0000, 32'h0080_0000);
    run_query(32'h0080_0000, ((NI - 1) << 24) + 1, 32'h0080_0000);
    run_query(32'h0080_0000, 32'h0080_0000, 32'h8000_0000);
    run_query(32'h7FFF_FFFF, 32'h0080_0000, 32'h0080_0000);
    drain();

    // random phases over several grid settings
    for (int p = 0; p < 10; p++) begin
      apply_mode(modes[p]);
      if (p == 3) press_go = 1;
      if (p == 9) quiet = 1;
      for (int n = 0; n < 35; n++) begin
        case ($urandom_range(0, 19))
          0, 1: run_query($urandom, $urandom, $urandom);
          2: write_word($urandom_range(0, 32767), $urandom);
          default: run_query(grid_coord(AX_T), grid_coord(AX_I), grid_coord(AX_O));
        endcase
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
